/* sv/hsl_pkg.sv */
// Shared types, fixed-point constants and helper functions for the HSL to RGB converter.
package hsl_pkg;

  // Unsigned 1.24 fixed point: one is 2^24.
  localparam logic [24:0] FX_ONE        = 25'd16777216;
  localparam logic [24:0] FX_HALF       = 25'd8388608;
  localparam logic [24:0] FX_ONE_THIRD  = 25'd5592405;
  localparam logic [24:0] FX_TWO_THIRDS = 25'd11184810;
  localparam logic signed [26:0] FX_ONE_S = 27'sd16777216;

  typedef logic [15:0] in16_t;   // raw 16-bit input field
  typedef logic [24:0] frac_t;   // fraction in 0..1
  typedef logic [25:0] pq_t;     // p, q and q - p, up to 2.0
  typedef logic [23:0] mult_t;   // ramp multiplier, below 1.0
  typedef logic [7:0]  chan_t;   // output channel intensity

  // Hue sector of one channel: rising ramp, flat top, falling ramp or floor.
  typedef enum logic [1:0] {
    SEC_RISE,
    SEC_TOP,
    SEC_FALL,
    SEC_LOW
  } sec_code_t;

  typedef struct packed {
    sec_code_t code;
    mult_t     mult;
  } sector_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } hsl_adv_t;

  // Stage 1 output: the three fractions and the zero-saturation flag.
  typedef struct packed {
    frac_t h;
    frac_t s;
    frac_t l;
    logic  grey;
  } frac_stage_t;

  // Stage 3 output: the common values every channel needs and the hue sector of each channel.
  typedef struct packed {
    pq_t     p;
    pq_t     d;
    logic    grey;
    chan_t   grey_val;
    sector_t sec_r;
    sector_t sec_g;
    sector_t sec_b;
  } pq_stage_t;

  // floor(x * 2^24 / 65535) without a divider: 2^24/65535 = 256 + 256/65535,
  // and the fractional part is one quotient step with a single correction.
  function automatic frac_t to_fraction(input in16_t x);
    logic [23:0] y;
    logic [7:0]  q0;
    logic [16:0] rem;
    logic [8:0]  quo;
    y   = {x, 8'd0};
    q0  = y[23:16];
    rem = {1'b0, y[15:0]} + {9'd0, q0};
    quo = {1'b0, q0} + ((rem >= 17'd65535) ? 9'd1 : 9'd0);
    return {1'b0, y} + {16'd0, quo};
  endfunction

  // Wraps a hue argument into 0..1 and picks its sixth of the circle.
  // An argument of exactly one is kept and lands on the floor.
  function automatic sector_t hue_sector(input logic signed [25:0] arg);
    logic signed [26:0] w;
    logic [24:0]        h;
    logic [27:0]        h6;
    logic [26:0]        h3;
    logic [24:0]        fall;
    logic [26:0]        f6;
    sector_t            r;
    w = {arg[25], arg};
    if (w < 27'sd0) begin
      w = w + FX_ONE_S;
    end else if (w > FX_ONE_S) begin
      w = w - FX_ONE_S;
    end
    h    = w[24:0];
    h6   = ({3'd0, h} << 2) + ({3'd0, h} << 1);
    h3   = ({2'd0, h} << 1) + {2'd0, h};
    fall = FX_TWO_THIRDS - h;
    f6   = ({2'd0, fall} << 2) + ({2'd0, fall} << 1);
    r.mult = '0;
    if (h6 < {3'd0, FX_ONE}) begin
      r.code = SEC_RISE;
      r.mult = h6[23:0];
    end else if ({h, 1'b0} < {1'b0, FX_ONE}) begin
      r.code = SEC_TOP;
    end else if (h3 < {1'b0, FX_ONE, 1'b0}) begin
      r.code = SEC_FALL;
      r.mult = f6[23:0];
    end else begin
      r.code = SEC_LOW;
    end
    return r;
  endfunction

endpackage

/* sv/hsl_frac.sv */
// Stage 1: converts the raw 16-bit inputs to 1.24 fractions.
module hsl_frac (
  input  logic                  clk,
  input  hsl_pkg::hsl_adv_t     adv,
  input  hsl_pkg::in16_t        hue,
  input  hsl_pkg::in16_t        saturation,
  input  hsl_pkg::in16_t        lightness,
  output hsl_pkg::frac_stage_t  st1
);
  import hsl_pkg::*;

  // Fraction registers; the grey flag marks a zero saturation input.
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      st1.h    <= to_fraction(hue);
      st1.s    <= to_fraction(saturation);
      st1.l    <= to_fraction(lightness);
      st1.grey <= (saturation == 16'd0);
    end
  end

endmodule

/* sv/hsl_pq.sv */
// Stages 2 and 3: the q product, the p and q - p values, the grey level
// and the hue sector of each channel.
module hsl_pq (
  input  logic                 clk,
  input  hsl_pkg::hsl_adv_t    adv,
  input  hsl_pkg::frac_stage_t st1,
  output hsl_pkg::pq_stage_t   st3
);
  import hsl_pkg::*;

  logic        lhalf;
  logic [25:0] mul_b;
  logic [50:0] mul_full;
  logic [32:0] grey_full;

  // Stage 2 registers.
  logic [24:0] prod;
  frac_t       l2;
  frac_t       s2;
  logic        lhalf2;
  logic        grey2;
  chan_t       grey_val2;
  sector_t     sec_r2;
  sector_t     sec_g2;
  sector_t     sec_b2;

  // Stage 3 combinational values.
  logic [25:0]        qraw;
  logic signed [26:0] pdiff;
  pq_t                pcl;
  pq_t                qcl;

  // One multiplier serves both forms of q: l*(1+s) below one half, s*l above.
  assign lhalf     = (st1.l < FX_HALF);
  assign mul_b     = lhalf ? ({1'b0, FX_ONE} + {1'b0, st1.s}) : {1'b0, st1.s};
  assign mul_full  = {26'd0, st1.l} * {25'd0, mul_b};
  assign grey_full = {st1.l, 8'd0} - {8'd0, st1.l};

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      prod      <= mul_full[48:24];
      l2        <= st1.l;
      s2        <= st1.s;
      lhalf2    <= lhalf;
      grey2     <= st1.grey;
      grey_val2 <= grey_full[31:24];
      sec_r2    <= hue_sector($signed({1'b0, st1.h}) + $signed({1'b0, FX_ONE_THIRD}));
      sec_g2    <= hue_sector($signed({1'b0, st1.h}));
      sec_b2    <= hue_sector($signed({1'b0, st1.h}) - $signed({1'b0, FX_ONE_THIRD}));
    end
  end

  // Finish q, derive p = 2l - q with a floor at zero, and keep q at or above p.
  assign qraw  = lhalf2 ? {1'b0, prod} : ({1'b0, l2} + {1'b0, s2} - {1'b0, prod});
  assign pdiff = $signed({1'b0, l2, 1'b0}) - $signed({1'b0, qraw});
  assign pcl   = pdiff[26] ? '0 : pdiff[25:0];
  assign qcl   = (qraw < pcl) ? pcl : qraw;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      st3.p        <= pcl;
      st3.d        <= qcl - pcl;
      st3.grey     <= grey2;
      st3.grey_val <= grey_val2;
      st3.sec_r    <= sec_r2;
      st3.sec_g    <= sec_g2;
      st3.sec_b    <= sec_b2;
    end
  end

endmodule

/* sv/hsl_chan.sv */
// Stages 4 and 5 of one color channel: ramp product, sum, scale and clamp.
module hsl_chan (
  input  logic              clk,
  input  hsl_pkg::hsl_adv_t adv,
  input  hsl_pkg::pq_t      p,
  input  hsl_pkg::pq_t      d,
  input  hsl_pkg::sector_t  sec,
  input  logic              grey,
  input  hsl_pkg::chan_t    grey_val,
  output hsl_pkg::chan_t    level
);
  import hsl_pkg::*;

  logic [49:0] mul_full;

  // Stage 4 registers.
  logic [25:0] prod_hi;
  pq_t         p4;
  pq_t         d4;
  sec_code_t   code4;
  logic        grey4;
  chan_t       grey_val4;

  logic [25:0] addend;
  logic [26:0] c;

  // Ramp product (q - p) times the sector multiplier.
  assign mul_full = {24'd0, d} * {26'd0, sec.mult};

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      prod_hi   <= mul_full[49:24];
      p4        <= p;
      d4        <= d;
      code4     <= sec.code;
      grey4     <= grey;
      grey_val4 <= grey_val;
    end
  end

  // Channel fraction: p plus the ramp, plus the full span on the flat top.
  always_comb begin
    case (code4)
      SEC_RISE, SEC_FALL: addend = prod_hi;
      SEC_TOP:            addend = d4;
      default:            addend = '0;
    endcase
  end

  assign c = {1'b0, p4} + {1'b0, addend};

  // Scale by 256 and clamp, or pass the grey level; a full-scale fraction would give 256.
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      if (grey4) begin
        level <= grey_val4;
      end else if (|c[26:24]) begin
        level <= 8'hFF;
      end else begin
        level <= c[23:16];
      end
    end
  end

endmodule

/* sv/hsl_to_rgb_converter_top.sv */
// Top level of the HSL to RGB converter: stream ports and pipeline control.
//
// Usage:
//   Input beats arrive on the s_ group; s_tdata carries hue, saturation and
//   lightness as 16-bit unsigned fractions where 65535 means one.
//   Result beats leave on the m_ group; m_tdata carries red, green and blue
//   as 8-bit intensities.
//   A beat is taken on any rising edge where tvalid and tready are both high.
// Stages and throughput:
//   Five register stages: fraction conversion, q product and hue sectors,
//   p and q - p, the three channel products, then sum, scale and clamp.
//   A beat passes through the stage registers in this order, and one beat
//   per cycle is accepted while the output is not stalled.
// Reset:
//   rst is synchronous and active high; it empties every stage, so no result
//   is offered after reset until a new beat has passed through.
// Stalls:
//   When m_tready is low the output register holds its beat, and the stages
//   behind it keep filling until each holds one beat; s_tready then drops.
//   Nothing is lost or repeated, and five beats can be in flight at once.
module hsl_to_rgb_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // hue [15:0], saturation [31:16], lightness [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red [7:0], green [15:8], blue [23:16]
);
  import hsl_pkg::*;

  logic [4:0]  vld;
  logic [4:0]  vld_next;
  logic [4:0]  rdy;
  hsl_adv_t    adv;

  frac_stage_t st1;
  pq_stage_t   st3;
  chan_t       red;
  chan_t       green;
  chan_t       blue;

  // A stage loads when it is empty or the stage after it moves on.
  assign rdy[4] = !vld[4] || m_tready;
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];

  assign adv.s1 = rdy[0];
  assign adv.s2 = rdy[1];
  assign adv.s3 = rdy[2];
  assign adv.s4 = rdy[3];
  assign adv.s5 = rdy[4];

  // Valid bits travel with the data.
  always_comb begin
    vld_next    = vld;
    if (rdy[0]) vld_next[0] = s_tvalid;
    if (rdy[1]) vld_next[1] = vld[0];
    if (rdy[2]) vld_next[2] = vld[1];
    if (rdy[3]) vld_next[3] = vld[2];
    if (rdy[4]) vld_next[4] = vld[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[4];
  assign m_tdata  = {blue, green, red};

  // Datapath stages.
  hsl_frac u_frac (
    .clk        (clk),
    .adv        (adv),
    .hue        (s_tdata[15:0]),
    .saturation (s_tdata[31:16]),
    .lightness  (s_tdata[47:32]),
    .st1        (st1)
  );

  hsl_pq u_pq (
    .clk (clk),
    .adv (adv),
    .st1 (st1),
    .st3 (st3)
  );

  hsl_chan u_chan_r (
    .clk      (clk),
    .adv      (adv),
    .p        (st3.p),
    .d        (st3.d),
    .sec      (st3.sec_r),
    .grey     (st3.grey),
    .grey_val (st3.grey_val),
    .level    (red)
  );

  hsl_chan u_chan_g (
    .clk      (clk),
    .adv      (adv),
    .p        (st3.p),
    .d        (st3.d),
    .sec      (st3.sec_g),
    .grey     (st3.grey),
    .grey_val (st3.grey_val),
    .level    (green)
  );

  hsl_chan u_chan_b (
    .clk      (clk),
    .adv      (adv),
    .p        (st3.p),
    .d        (st3.d),
    .sec      (st3.sec_b),
    .grey     (st3.grey),
    .grey_val (st3.grey_val),
    .level    (blue)
  );

  // A ready receiver leaves room for a new beat all the way back.
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while the receiver was ready");

  // Input backpressure only when every stage is full behind a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && (vld == 5'b11111)))
    else $error("input stalled without a full pipeline");

  // With the receiver ready, a taken beat passes through every stage and appears at the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
    |=> m_tvalid)
    else $error("result did not appear after five cycles");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == 5'b00000))
    else $error("pipeline not empty after reset");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the HSL to RGB converter stream block.
module tb_top;

  // Unsigned 2.24 fixed point used by the color math.
  localparam longint FRAC_ONE   = 64'd16777216;
  localparam longint FRAC_HALF  = 64'd8388608;
  localparam longint ONE_THIRD  = 64'd5592405;
  localparam longint TWO_THIRDS = 64'd11184810;

  // Run control.
  localparam int RANDOM_BEATS   = 800;
  localparam int IDLE_PERCENT   = 9;
  localparam int PAUSE_AT       = 500;
  localparam int BURST_FIRST    = 200;
  localparam int BURST_LAST     = 350;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 60;
  localparam int STEADY_FIRST   = 400;
  localparam int STEADY_LAST    = 600;
  localparam int DRAIN_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 20;

  typedef struct packed {
    logic [15:0] lightness;
    logic [15:0] saturation;
    logic [15:0] hue;
  } hsl_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // hue [15:0], saturation [31:16], lightness [47:32]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // red [7:0], green [15:8], blue [23:16]

  hsl_t   pending_hsl[$];
  rgb_t   expected_rgb[$];
  int     sent_cnt = 0;
  int     got_cnt = 0;
  int     total_beats = 0;
  int     errors = 0;
  int     cycles = 0;
  int     hold_left = 0;
  logic   held_off = 1'b0;

  hsl_to_rgb_converter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Maps a 16-bit input to floor(x * 2^24 / 65535).
  function automatic longint fraction_of(input logic [15:0] x);
    longint wide;
    wide = longint'(x);
    return (wide << 24) / 65535;
  endfunction

  // Piecewise hue helper, with the wrap into 0..1 applied first.
  function automatic longint channel_level(input longint p, input longint q, input longint arg);
    longint d;
    longint h;
    d = q - p;
    h = arg;
    if (h < 0) begin
      h = h + FRAC_ONE;
    end
    if (h > FRAC_ONE) begin
      h = h - FRAC_ONE;
    end
    if (6 * h < FRAC_ONE) begin
      return p + ((d * 6 * h) >> 24);
    end
    if (2 * h < FRAC_ONE) begin
      return q;
    end
    if (3 * h < 2 * FRAC_ONE) begin
      return p + ((d * (TWO_THIRDS - h) * 6) >> 24);
    end
    return p;
  endfunction

  // Scales a channel fraction by 256 and clamps it into a byte.
  function automatic logic [7:0] channel_byte(input longint c);
    longint v;
    if (c <= 0) begin
      return 8'd0;
    end
    v = c >> 16;
    if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  // Expected color for one input triple.
  function automatic rgb_t hsl_to_rgb(input hsl_t px);
    longint h;
    longint s;
    longint l;
    longint p;
    longint q;
    longint g;
    rgb_t   c;
    h = fraction_of(px.hue);
    s = fraction_of(px.saturation);
    l = fraction_of(px.lightness);
    // A zero saturation gives a grey of lightness times 255.
    if (s == 0) begin
      g = (l * 255) >> 24;
      if (g > 255) begin
        g = 255;
      end
      c.red   = g[7:0];
      c.green = g[7:0];
      c.blue  = g[7:0];
      return c;
    end
    if (l < FRAC_HALF) begin
      q = (l * (FRAC_ONE + s)) >> 24;
    end else begin
      q = l + s - ((s * l) >> 24);
    end
    p = 2 * l - q;
    if (p < 0) begin
      p = 0;
    end
    if (q < p) begin
      q = p;
    end
    c.red   = channel_byte(channel_level(p, q, h + ONE_THIRD));
    c.green = channel_byte(channel_level(p, q, h));
    c.blue  = channel_byte(channel_level(p, q, h - ONE_THIRD));
    return c;
  endfunction

  function automatic hsl_t make_hsl(input int h, input int s, input int l);
    hsl_t px;
    px.hue        = h[15:0];
    px.saturation = s[15:0];
    px.lightness  = l[15:0];
    return px;
  endfunction

  // Picks a value near a field edge or the lightness midpoint.
  function automatic logic [15:0] edge_value();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd32767;
      3: return 16'd32768;
      4: return 16'd65534;
      default: return 16'd65535;
    endcase
  endfunction

  // Stimulus: directed corners first, then random triples.
  initial begin : stimulus
    hsl_t px;
    int   kind;
    // Grey inputs, including full white and a mid grey.
    pending_hsl.push_back(make_hsl(0, 0, 0));
    pending_hsl.push_back(make_hsl(65535, 0, 65535));
    pending_hsl.push_back(make_hsl(12345, 0, 32768));
    pending_hsl.push_back(make_hsl(0, 0, 1));
    // Full saturation and lightness: channels reach 1.0 and clamp at 255.
    pending_hsl.push_back(make_hsl(0, 65535, 65535));
    pending_hsl.push_back(make_hsl(65535, 65535, 65535));
    // Lightness on both sides of one half selects the two q formulas.
    pending_hsl.push_back(make_hsl(5000, 65535, 32767));
    pending_hsl.push_back(make_hsl(5000, 65535, 32768));
    pending_hsl.push_back(make_hsl(40000, 1, 32768));
    pending_hsl.push_back(make_hsl(20000, 65535, 0));
    // Hue around every sixth of the circle, and the wrap ends.
    pending_hsl.push_back(make_hsl(0, 65535, 32768));
    pending_hsl.push_back(make_hsl(65535, 65535, 32768));
    pending_hsl.push_back(make_hsl(10922, 65535, 32768));
    pending_hsl.push_back(make_hsl(10923, 65535, 32768));
    pending_hsl.push_back(make_hsl(21845, 65535, 32768));
    pending_hsl.push_back(make_hsl(21846, 65535, 32768));
    pending_hsl.push_back(make_hsl(32767, 65535, 32768));
    pending_hsl.push_back(make_hsl(32768, 65535, 32768));
    pending_hsl.push_back(make_hsl(43690, 65535, 32768));
    pending_hsl.push_back(make_hsl(43691, 65535, 32768));
    pending_hsl.push_back(make_hsl(54612, 40000, 20000));
    pending_hsl.push_back(make_hsl(54613, 40000, 50000));
    pending_hsl.push_back(make_hsl(65534, 30000, 10000));
    pending_hsl.push_back(make_hsl(1, 65534, 65534));
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      kind = int'($urandom_range(9));
      px.hue        = 16'($urandom_range(65535));
      px.saturation = 16'($urandom_range(65535));
      px.lightness  = 16'($urandom_range(65535));
      if (kind < 2) begin
        px.saturation = 16'd0;
      end else if (kind == 2) begin
        px.saturation = edge_value();
        px.lightness  = edge_value();
        if ($urandom_range(1) == 0) begin
          px.hue = edge_value();
        end
      end
      pending_hsl.push_back(px);
    end
    total_beats = pending_hsl.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for every beat to be taken and answered, then let the pipe settle.
    while (!(sent_cnt == total_beats && got_cnt == total_beats)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rgb.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_rgb.size());
      errors++;
    end
    $display("Converted %0d triples: grey, clamped white, hue sixth boundaries, random colors,",
             got_cnt);
    $display("with input gaps, output stalls, a long output hold-off and a drain pause.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Driver: offers queued triples, predicting the color of each taken beat.
  always @(posedge clk) begin : driver
    logic taken;
    logic offer;
    int   sent_next;
    taken = s_tvalid && s_tready;
    sent_next = sent_cnt + (taken ? 1 : 0);
    if (taken) begin
      expected_rgb.push_back(hsl_to_rgb(hsl_t'(s_tdata)));
    end
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !taken)) begin
      offer = (pending_hsl.size() != 0);
      // Once, stop offering until every result so far has come back.
      if (sent_next == PAUSE_AT && got_cnt != sent_next) begin
        offer = 1'b0;
      end else if (!(sent_next >= BURST_FIRST && sent_next < BURST_LAST) &&
                   $urandom_range(99) < IDLE_PERCENT) begin
        offer = 1'b0;
      end
      if (offer) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_hsl.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    sent_cnt <= sent_next;
  end

  // Monitor: checks each result beat and drives the output backpressure.
  always @(posedge clk) begin : monitor
    rgb_t actual;
    rgb_t want;
    actual = rgb_t'(m_tdata);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rgb.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $display("%0t: result %h arrived with nothing expected", $time, actual);
        end
        errors++;
      end else begin
        want = expected_rgb.pop_front();
        if (want.red !== actual.red) begin
          if (errors < MAX_REPORTS) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, actual.red);
          end
          errors++;
        end
        if (want.green !== actual.green) begin
          if (errors < MAX_REPORTS) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, actual.green);
          end
          errors++;
        end
        if (want.blue !== actual.blue) begin
          if (errors < MAX_REPORTS) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, actual.blue);
          end
          errors++;
        end
      end
      got_cnt <= got_cnt + 1;
    end

    // One long hold-off fills the pipeline; a steady window keeps ready high; otherwise stall at random.
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!held_off && got_cnt >= HOLD_AT) begin
      held_off  <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (got_cnt >= STEADY_FIRST && got_cnt < STEADY_LAST) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d of %0d results seen",
               $time, cycles, got_cnt, total_beats);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

/* hsl_to_rgb_converter_top.f */
sv/hsl_pkg.sv
sv/hsl_frac.sv
sv/hsl_pq.sv
sv/hsl_chan.sv
sv/hsl_to_rgb_converter_top.sv
tb/sv/tb_top.sv
